// ===== rtl/tqme_pkg.sv =====
// ----------------------------------------------------------------------------
// tqme_pkg
// Shared types, constants and the wall block table of the tile quad emitter.
// ----------------------------------------------------------------------------
package tqme_pkg;

  localparam int unsigned CoordW   = 20;
  localparam int unsigned OutW     = 18;
  localparam int unsigned CountW   = 21;
  localparam int unsigned IndexW   = 20;
  localparam int unsigned NumSlots = 14;
  localparam int unsigned SlotW    = 4;

  localparam logic signed [CoordW-1:0] One = CoordW'(256);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CountW-1:0] CapReset = CountW'(65536);

  localparam logic [3:0] WallNone     = 4'd0;
  localparam logic [3:0] WallBlockMax = 4'd6;
  localparam logic [3:0] WallDiagMin  = 4'd7;
  localparam logic [3:0] WallDiagMax  = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMIT
  } state_e;

  // one quad: origin, spans, layer, slanted face select
  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic [7:0]               layer;
    logic                     slant;
  } quad_t;

  typedef struct packed {
    logic [8:0] off_x;
    logic [8:0] off_z;
    logic [8:0] size_x;
    logic [8:0] size_z;
  } blk_t;

  function automatic blk_t blk_lookup(input logic [3:0] wtype);
    blk_t b;
    b = '0;
    case (wtype)
      4'd1: b = '{9'd0,   9'd0,   9'd256, 9'd256};
      4'd2: b = '{9'd0,   9'd0,   9'd256, 9'd128};
      4'd3: b = '{9'd0,   9'd128, 9'd256, 9'd128};
      4'd4: b = '{9'd0,   9'd0,   9'd128, 9'd256};
      4'd5: b = '{9'd128, 9'd0,   9'd128, 9'd256};
      4'd6: b = '{9'd64,  9'd64,  9'd128, 9'd128};
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/tile_quad_mesh_emitter.sv =====
// A fourteen-slot quad sequencer drives one shared vertex adder. A tile accept
// moves it to ST_PREP, which registers the slot mask; ST_EMIT then loads one
// vertex per cycle into the output register while the output is not stalled,
// skipping empty slots up to the last used one; new tiles are taken in ST_IDLE.
// Reset clears vertex count, overflow flag and sequencer; capacity to 65536.
// ----------------------------------------------------------------------------
// tile_quad_mesh_emitter
// Emits a grid tile's quad vertices, one vertex word per cycle unless stalled.
// ----------------------------------------------------------------------------
module tile_quad_mesh_emitter import tqme_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CountW-1:0]      cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   chunk_start_i,
  input  logic [7:0]             tile_x_i,
  input  logic [7:0]             tile_z_i,
  input  logic signed [15:0]     bot_height_i,
  input  logic signed [15:0]     top_height_i,
  input  logic [3:0]             wall_type_i,
  input  logic [7:0]             wall_texture_i,
  input  logic [15:0]            floor_ceiling_textures_i,
  input  logic [15:0]            window_textures_i,
  input  logic [3:0]             neighbor_present_i,
  input  logic [63:0]            neighbor_bot_heights_i,
  input  logic [63:0]            neighbor_top_heights_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] pos_x_o,
  output logic signed [OutW-1:0] pos_y_o,
  output logic signed [OutW-1:0] pos_z_o,
  output logic signed [OutW-1:0] tex_u_o,
  output logic signed [OutW-1:0] tex_v_o,
  output logic [7:0]             layer_o,
  output logic [IndexW-1:0]      vertex_index_o,
  output logic                   last_vertex_o,
  output logic                   overflow_o
);

  state_e state_q, state_d;
  logic [CountW-1:0] cap_q, count_q, count_d;
  logic overflow_q, overflow_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [1:0] k_q, k_d;
  logic [NumSlots-1:0] mask_q, mask_d;

  // captured tile
  logic [7:0] tx_q, tz_q, wtex_q;
  logic signed [15:0] bot_q, top_q;
  logic [3:0] wtype_q, pres_q;
  logic [15:0] fct_q, wint_q;
  logic [63:0] nbot_q, ntop_q;

  logic in_acc, out_free, emit;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;

  // operands
  logic signed [CoordW-1:0] xb, zb, bot, top, h;
  logic signed [CoordW-1:0] db [4];
  logic signed [CoordW-1:0] dt [4];
  assign xb  = {4'b0, tx_q, 8'b0};
  assign zb  = {4'b0, tz_q, 8'b0};
  assign bot = {{4{bot_q[15]}}, bot_q};
  assign top = {{4{top_q[15]}}, top_q};
  assign h   = top - bot;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (pres_q[i]) begin
        db[i] = {{4{nbot_q[16*i+15]}}, nbot_q[16*i +: 16]} - bot;
        dt[i] = {{4{ntop_q[16*i+15]}}, ntop_q[16*i +: 16]} - top;
      end else begin
        db[i] = '0;
        dt[i] = '0;
      end
    end
  end

  logic is_blk, is_diag, rising;
  logic [1:0] dflag;
  blk_t blk;
  logic signed [CoordW-1:0] sx, sz, wx, wz;
  assign is_blk  = (wtype_q != WallNone) && (wtype_q <= WallBlockMax);
  assign is_diag = (wtype_q >= WallDiagMin) && (wtype_q <= WallDiagMax);
  assign dflag   = 2'(wtype_q - WallDiagMin);
  assign rising  = (dflag == 2'd0) || (dflag == 2'd3);
  assign blk     = blk_lookup(wtype_q);
  assign sx = xb + CoordW'(blk.off_x);
  assign sz = zb + CoordW'(blk.off_z);
  assign wx = CoordW'(blk.size_x);
  assign wz = CoordW'(blk.size_z);

  always_comb begin
    mask_d = '0;
    mask_d[0]  = db[0] < 0;
    mask_d[1]  = dt[0] > 0;
    mask_d[2]  = db[1] < 0;
    mask_d[3]  = dt[1] > 0;
    mask_d[4]  = bot != top;
    mask_d[5]  = bot != top;
    mask_d[6]  = db[2] < 0;
    mask_d[7]  = dt[2] > 0;
    mask_d[8]  = db[3] < 0;
    mask_d[9]  = dt[3] > 0;
    mask_d[10] = is_blk || is_diag;
    mask_d[11] = is_blk || is_diag;
    mask_d[12] = is_blk || is_diag;
    mask_d[13] = is_blk;
  end

  quad_t q;
  logic [7:0] low_l, high_l;
  assign low_l  = wint_q[7:0];
  assign high_l = wint_q[15:8];

  always_comb begin
    q = '{px: xb, py: bot, pz: zb, ax: '0, ay: '0, az: '0, layer: '0, slant: 1'b0};
    case (slot_q)
      4'd0: begin q.ay = db[0]; q.az = One; q.layer = low_l; end
      4'd1: begin q.py = top; q.ay = dt[0]; q.az = One; q.layer = high_l; end
      4'd2: begin q.px = xb + One; q.ay = db[1]; q.az = One; q.layer = low_l; end
      4'd3: begin
        q.px = xb + One; q.py = top; q.ay = dt[1]; q.az = One; q.layer = high_l;
      end
      4'd4: begin q.ax = One; q.az = One; q.layer = fct_q[7:0]; end
      4'd5: begin q.py = top; q.ax = One; q.az = One; q.layer = fct_q[15:8]; end
      4'd6: begin q.ax = One; q.ay = db[2]; q.layer = low_l; end
      4'd7: begin q.py = top; q.ax = One; q.ay = dt[2]; q.layer = high_l; end
      4'd8: begin q.pz = zb + One; q.ax = One; q.ay = db[3]; q.layer = low_l; end
      4'd9: begin
        q.pz = zb + One; q.py = top; q.ax = One; q.ay = dt[3]; q.layer = high_l;
      end
      4'd10: begin
        q.layer = wtex_q; q.ay = h;
        if (is_blk) begin
          q.px = sx; q.pz = sz; q.az = wz;
        end else begin
          q.px = dflag[0] ? xb + One : xb; q.az = One;
        end
      end
      4'd11: begin
        q.layer = wtex_q; q.ay = h;
        if (is_blk) begin
          q.px = sx; q.pz = sz; q.ax = wx;
        end else begin
          q.pz = dflag[1] ? zb + One : zb; q.ax = One;
        end
      end
      4'd12: begin
        q.layer = wtex_q; q.ay = h;
        if (is_blk) begin
          q.px = sx + wx; q.pz = sz; q.az = wz;
        end else begin
          q.slant = 1'b1; q.az = One;
          q.px = rising ? xb + One : xb;
          q.ax = rising ? -One : One;
        end
      end
      4'd13: begin q.layer = wtex_q; q.px = sx; q.pz = sz + wz; q.ax = wx; q.ay = h; end
      default: q.layer = wtex_q;
    endcase
  end

  logic signed [OutW-1:0] vx, vy, vz, vu, vv;
  tqme_vertex_unit u_vertex (
    .quad_i   (q),
    .corner_i (k_q),
    .x_o      (vx),
    .y_o      (vy),
    .z_o      (vz),
    .u_o      (vu),
    .v_o      (vv)
  );

  logic slot_on, no_later, flag_now;
  logic [CountW:0] count_p4;
  assign slot_on  = mask_q[slot_q];
  assign no_later = ((mask_q >> slot_q) >> 1) == '0;
  assign count_p4 = {1'b0, count_q} + (CountW+1)'(4);
  assign flag_now = overflow_q || ((k_q == 2'd3) && (count_p4 > {1'b0, cap_q}));
  assign emit     = (state_q == ST_EMIT) && slot_on && out_free;

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    k_d        = k_q;
    count_d    = count_q;
    overflow_d = overflow_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_PREP;
          if (chunk_start_i) begin
            count_d    = '0;
            overflow_d = 1'b0;
          end
        end
      end
      ST_PREP: begin
        slot_d  = '0;
        k_d     = 2'd3;
        state_d = (mask_d == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (!slot_on) begin
          if (slot_q == SlotW'(NumSlots - 1)) state_d = ST_IDLE;
          else slot_d = slot_q + 1'b1;
        end else if (out_free) begin
          overflow_d = flag_now;
          if (count_q != CountMax) count_d = count_q + 1'b1;
          k_d = k_q - 1'b1;
          if (k_q == 2'd0) begin
            if (no_later) state_d = ST_IDLE;
            else slot_d = slot_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CapReset;
      count_q     <= '0;
      overflow_q  <= 1'b0;
      slot_q      <= '0;
      k_q         <= 2'd3;
      mask_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      overflow_q <= overflow_d;
      slot_q     <= slot_d;
      k_q        <= k_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (state_q == ST_PREP) mask_q <= mask_d;
      if (emit) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tx_q   <= tile_x_i;
      tz_q   <= tile_z_i;
      bot_q  <= bot_height_i;
      top_q  <= top_height_i;
      wtype_q <= wall_type_i;
      wtex_q <= wall_texture_i;
      fct_q  <= floor_ceiling_textures_i;
      wint_q <= window_textures_i;
      pres_q <= neighbor_present_i;
      nbot_q <= neighbor_bot_heights_i;
      ntop_q <= neighbor_top_heights_i;
    end
    if (emit) begin
      pos_x_o        <= vx;
      pos_y_o        <= vy;
      pos_z_o        <= vz;
      tex_u_o        <= vu;
      tex_v_o        <= vv;
      layer_o        <= q.layer;
      vertex_index_o <= count_q[IndexW-1:0];
      last_vertex_o  <= (k_q == 2'd0) && no_later;
      overflow_o     <= flag_now;
    end
  end

`ifndef SYNTHESIS
  a_mid_quad_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && k_q != 2'd3) |-> mask_q[slot_q])
    else $error("partial quad in disabled slot");
  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (overflow_q && !(in_acc && chunk_start_i)) |=> overflow_q)
    else $error("overflow flag dropped");
  a_prep_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_PREP && !in_ready_o))
    else $error("tile accept not followed by prep");
`endif

endmodule

// ===== rtl/tqme_vertex_unit.sv =====
// ----------------------------------------------------------------------------
// tqme_vertex_unit
// Shared adder unit: one vertex of a quad from its corner code.
// ----------------------------------------------------------------------------
module tqme_vertex_unit import tqme_pkg::*; (
  input  quad_t                 quad_i,
  input  logic [1:0]            corner_i,
  output logic signed [OutW-1:0] x_o,
  output logic signed [OutW-1:0] y_o,
  output logic signed [OutW-1:0] z_o,
  output logic signed [OutW-1:0] u_o,
  output logic signed [OutW-1:0] v_o
);

  logic signed [CoordW-1:0] dx, dy, dz, u, v;
  logic k0, k1;

  assign k0 = corner_i[0];
  assign k1 = corner_i[1];

  always_comb begin
    dx = '0;
    dy = '0;
    dz = '0;
    if (quad_i.slant) begin
      dx = k0 ? quad_i.ax : '0;
      dy = k1 ? quad_i.ay : '0;
      dz = k0 ? quad_i.az : '0;
      u  = k0 ? One : '0;
      v  = dy;
    end else if (quad_i.ax == '0) begin
      dy = k0 ? quad_i.ay : '0;
      dz = k1 ? quad_i.az : '0;
      u  = quad_i.pz + dz;
      v  = quad_i.py + dy;
    end else if (quad_i.ay == '0) begin
      // horizontal plane: v runs along z
      dx = k0 ? quad_i.ax : '0;
      dz = k1 ? quad_i.az : '0;
      u  = quad_i.px + dx;
      v  = quad_i.pz + dz;
    end else begin
      dx = k0 ? quad_i.ax : '0;
      dy = k1 ? quad_i.ay : '0;
      u  = quad_i.px + dx;
      v  = quad_i.py + dy;
    end
  end

  logic signed [CoordW-1:0] sx, sy, sz;
  assign sx = quad_i.px + dx;
  assign sy = quad_i.py + dy;
  assign sz = quad_i.pz + dz;

  assign x_o = sx[OutW-1:0];
  assign y_o = sy[OutW-1:0];
  assign z_o = sz[OutW-1:0];
  assign u_o = u[OutW-1:0];
  assign v_o = v[OutW-1:0];

endmodule
